@@ src/art_pkg.sv @@
// Shared types, constants and byte functions of the AES round transform unit.
package art_pkg;

   localparam int BYTE_W  = 8;
   localparam int COL_W   = 32;
   localparam int STATE_W = 128;
   localparam int NUM_COL = 4;
   localparam int NUM_ROW = 4;

   localparam logic [7:0] GF_REDUCE = 8'h1b;

   typedef enum logic [1:0] {
      CMD_ADD_KEY     = 2'd0,
      CMD_SUB_BYTES   = 2'd1,
      CMD_SHIFT_ROWS  = 2'd2,
      CMD_MIX_COLUMNS = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
      8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
      8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
      8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
      8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
      8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
      8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
      8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
      8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
      8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
      8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
      8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
      8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
      8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
      8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
      8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
      8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
      8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
      8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
      8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
      8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
      8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
      8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
      8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
      8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
      8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
      8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
      8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
      8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
      8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
   };

   // Multiply by x in GF(2^8), reduce by the AES polynomial.
   function automatic logic [7:0] gf_double(input logic [7:0] x);
      logic [7:0] y;
      y = {x[6:0], 1'b0};
      if (x[7]) begin
         y = y ^ GF_REDUCE;
      end
      return y;
   endfunction

endpackage

@@ src/art_lane.sv @@
// One column lane: key add, S-box and column mix on four state bytes.
module art_lane (
   input  art_pkg::cmd_type     cmd,
   input  logic [31:0]          col_state,
   input  logic [31:0]          col_key,
   output logic [31:0]          col_result
);
   import art_pkg::*;

   logic [7:0] a [NUM_ROW];
   logic [7:0] d [NUM_ROW];
   logic [7:0] s [NUM_ROW];
   logic [31:0] mix;

   // Row 0 sits in the top byte of the column word.
   always_comb begin
      for (int r = 0; r < NUM_ROW; r++) begin
         a[r] = col_state[COL_W - 1 - BYTE_W * r -: BYTE_W];
         d[r] = gf_double(a[r]);
         s[r] = SBOX[a[r]];
      end
   end

   assign mix = {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
                 a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
                 a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
                 d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};

   // Shift rows crosses columns and is done in the merge stage; pass through.
   always_comb begin
      case (cmd)
         CMD_ADD_KEY:     col_result = col_state ^ col_key;
         CMD_SUB_BYTES:   col_result = {s[0], s[1], s[2], s[3]};
         CMD_MIX_COLUMNS: col_result = mix;
         default:         col_result = col_state;
      endcase
   end

endmodule

@@ src/art_merge.sv @@
// Merge stage: join lane columns, apply row shifts, register the result.
module art_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  art_pkg::cmd_type     cmd,
   input  logic [127:0]         state_in,
   input  logic [127:0]         lane_result,
   output logic                 rsp_strobe,
   output art_pkg::rsp_type     rsp_item
);
   import art_pkg::*;

   logic [127:0] shifted;
   logic [127:0] result_in;
   logic [127:0] result_ff;
   logic         strobe_ff;

   // Byte k of the state lives at bits 127-8k down.
   always_comb begin
      shifted = '0;
      for (int c = 0; c < NUM_COL; c++) begin
         for (int r = 0; r < NUM_ROW; r++) begin
            shifted[STATE_W - 1 - BYTE_W * (c * NUM_ROW + r) -: BYTE_W] =
               state_in[STATE_W - 1 - BYTE_W * (((c + r) % NUM_COL) * NUM_ROW + r) -: BYTE_W];
         end
      end
   end

   always_comb begin
      case (cmd)
         CMD_SHIFT_ROWS: result_in = shifted;
         default:        result_in = lane_result;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_item.result_hi = result_ff[127:64];
   assign rsp_item.result_lo = result_ff[63:0];

endmodule

@@ src/aes_round_transform_unit_top.sv @@
// Top level of the AES-128 round transform unit.
//
// Applies one AES round transformation per item to a 128-bit state held in
// column-major byte order (byte k = column*4 + row, byte 0 in bits 63:56 of
// block_hi): add round key, sub bytes, shift rows or mix columns, chosen by
// cmd. An item is taken on any clock edge with start high; busy never rises,
// so a new item can be issued every cycle. The result shows on rsp_item,
// flagged by rsp_strobe for exactly one cycle, in the cycle after the item was
// taken; the receiver cannot stall and must capture it then. Throughput is
// one item per cycle, with the single output register after the four column
// lanes and the merge stage. The key is used only by
// add round key. Nothing is kept between items; reset only clears the strobe.
module aes_round_transform_unit_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  art_pkg::req_type     req_item,
   output logic                 rsp_strobe,
   output art_pkg::rsp_type     rsp_item
);
   import art_pkg::*;

   logic         accept;
   logic [127:0] state_word;
   logic [127:0] key_word;
   logic [127:0] lane_result;

   // No multi-cycle work anywhere: always ready for the next item.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign state_word = {req_item.block_hi, req_item.block_lo};
   assign key_word   = {req_item.key_hi, req_item.key_lo};

   // One lane per state column; column 0 holds the top 32 bits.
   for (genvar c = 0; c < NUM_COL; c++) begin : g_lane
      art_lane u_lane (
         .cmd        (req_item.cmd),
         .col_state  (state_word[STATE_W - 1 - COL_W * c -: COL_W]),
         .col_key    (key_word[STATE_W - 1 - COL_W * c -: COL_W]),
         .col_result (lane_result[STATE_W - 1 - COL_W * c -: COL_W])
      );
   end

   // Join columns, handle the cross-column row shift and hold the result.
   art_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_item.cmd),
      .state_in    (state_word),
      .lane_result (lane_result),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule

@@ src/art_checker.sv @@
// Port-level checks for the AES round transform unit, bound to the top level.
module art_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  art_pkg::req_type     req_item,
   input  logic                 rsp_strobe,
   input  art_pkg::rsp_type     rsp_item
);
   import art_pkg::*;

   logic accept;
   assign accept = start && !busy;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted item gave no result next cycle");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("result without an accepted item");

   a_add_key: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_ADD_KEY) |=>
         (rsp_item.result_hi == $past(req_item.block_hi ^ req_item.key_hi)) &&
         (rsp_item.result_lo == $past(req_item.block_lo ^ req_item.key_lo)))
      else $error("add round key result mismatch");

   a_shift_row0: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_SHIFT_ROWS) |=>
         (rsp_item.result_hi[63:56] == $past(req_item.block_hi[63:56])) &&
         (rsp_item.result_lo[63:56] == $past(req_item.block_lo[63:56])))
      else $error("shift rows moved row zero");

endmodule

bind aes_round_transform_unit_top art_checker u_art_checker (.*);
